// ===== hw/rtl/fifo_recent_id_list_top_macros.svh =====
// ----------------------------------------------------------------------------
// fifo recent id list assertion macros
// shared assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef FIFO_RECENT_ID_LIST_TOP_MACROS_SVH
`define FIFO_RECENT_ID_LIST_TOP_MACROS_SVH

// checked only outside reset
`define FRL_ASSERT_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define FRL_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/frl_pkg.sv =====
// ----------------------------------------------------------------------------
// frl_pkg
// shared widths, defaults and item types of the recent id list
// ----------------------------------------------------------------------------
package frl_pkg;

    localparam int IDENT_W         = 32;
    localparam int COUNT_W         = 5;
    localparam int CFG_W           = 5;
    localparam int DEPTH_DEFAULT   = 16;
    localparam int ID_BITS_DEFAULT = 32;

    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic
    {
        KIND_PLAIN,
        KIND_END
    } item_kind_t;

    typedef struct packed
    {
        logic [IDENT_W-1:0] ident;
        item_kind_t         kind;
    } frl_item_t;

endpackage

// ===== hw/rtl/frl_channels.sv =====
// ----------------------------------------------------------------------------
// frl channels
// valid/ready channels for incoming identifiers and dumped entries
// ----------------------------------------------------------------------------
interface frl_in_if;
    import frl_pkg::*;

    logic               valid;
    logic               ready;
    logic [IDENT_W-1:0] ident;
    logic               batch_end;

    modport source
    (
        output valid,
        input  ready,
        output ident,
        output batch_end
    );

    modport sink
    (
        input  valid,
        output ready,
        input  ident,
        input  batch_end
    );
endinterface

interface frl_out_if;
    import frl_pkg::*;

    logic               valid;
    logic               ready;
    logic [IDENT_W-1:0] entry_ident;
    logic [COUNT_W-1:0] stored_count;
    logic               final_entry;

    modport source
    (
        output valid,
        input  ready,
        output entry_ident,
        output stored_count,
        output final_entry
    );

    modport sink
    (
        input  valid,
        output ready,
        input  entry_ident,
        input  stored_count,
        input  final_entry
    );
endinterface

// ===== hw/rtl/frl_front.sv =====
// ----------------------------------------------------------------------------
// frl_front
// accepts identifier transactions, tags batch ends, queues them for the back
// ----------------------------------------------------------------------------
module frl_front
(
    input  logic              clk,
    input  logic              rst_n,
    frl_in_if.sink            ident_ch,
    output frl_pkg::frl_item_t q_head,
    output logic              q_valid,
    input  logic              q_pop
);
    import frl_pkg::*;

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    frl_item_t             entry_reg [QUEUE_DEPTH];
    logic      [PTR_W-1:0] wr_ptr_reg;
    logic      [PTR_W-1:0] wr_ptr_next;
    logic      [PTR_W-1:0] rd_ptr_reg;
    logic      [PTR_W-1:0] rd_ptr_next;
    logic      [CNT_W-1:0] count_reg;
    logic      [CNT_W-1:0] count_next;
    logic                  push;
    frl_item_t             item_new;

    assign ident_ch.ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push           = ident_ch.valid && ident_ch.ready;
    assign q_valid        = (count_reg != '0);
    assign q_head         = entry_reg[rd_ptr_reg];

    // classify the transaction
    always_comb
    begin
        item_new.ident = ident_ch.ident;
        item_new.kind  = ident_ch.batch_end ? KIND_END : KIND_PLAIN;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= item_new;
        end
    end

endmodule

// ===== hw/rtl/frl_back.sv =====
// ----------------------------------------------------------------------------
// frl_back
// applies queued identifiers to the shift list and dumps it on batch end
// ----------------------------------------------------------------------------
module frl_back
#(
    parameter int DEPTH   = frl_pkg::DEPTH_DEFAULT,
    parameter int ID_BITS = frl_pkg::ID_BITS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [frl_pkg::CFG_W-1:0] cfg_wdata,
    input  frl_pkg::frl_item_t        q_head,
    input  logic                      q_valid,
    output logic                      q_pop,
    frl_out_if.source                 result_ch
);
    import frl_pkg::*;

    localparam int CW = ($clog2(DEPTH + 1) > CFG_W) ? $clog2(DEPTH + 1) : CFG_W;

    typedef enum logic
    {
        ST_IDLE,
        ST_DUMP
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [CW-1:0]        fill_reg;
    logic [CW-1:0]        fill_next;
    logic [CW-1:0]        remain_reg;
    logic [CW-1:0]        remain_next;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [CFG_W-1:0]     cap_reg;
    logic [CFG_W-1:0]     cap_next;
    logic [ID_BITS-1:0]   slots_reg  [DEPTH];
    logic [ID_BITS-1:0]   slots_next [DEPTH];
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [IDENT_W-1:0]   out_ident_reg;
    logic [IDENT_W-1:0]   out_ident_next;
    logic [COUNT_W-1:0]   out_count_reg;
    logic [COUNT_W-1:0]   out_count_next;
    logic                 out_final_reg;
    logic                 out_final_next;

    logic [ID_BITS-1:0]   id_cur;
    logic                 hit;
    logic [CW-1:0]        cap_ext;
    logic [CW-1:0]        cap_eff;
    logic [CW-1:0]        keep;
    logic [CW-1:0]        new_fill;
    logic [63:0]          head_wide;
    logic                 do_load;
    logic                 out_take;

    assign id_cur    = ID_BITS'(q_head.ident);
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign out_take  = out_valid_reg && result_ch.ready;
    assign do_load   = (state_reg == ST_DUMP) && (!out_valid_reg || result_ch.ready);
    assign head_wide = 64'(slots_reg[0]);

    assign result_ch.valid        = out_valid_reg;
    assign result_ch.entry_ident  = out_ident_reg;
    assign result_ch.stored_count = out_count_reg;
    assign result_ch.final_entry  = out_final_reg;

    // compare against every held slot
    always_comb
    begin
        hit = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if ((CW'(i) < fill_reg) && (slots_reg[i] == id_cur))
            begin
                hit = 1'b1;
            end
        end
    end

    // zero counts as one, saturate to depth
    always_comb
    begin
        cap_ext = CW'(cap_reg);
        if (cap_ext == '0)
        begin
            cap_eff = CW'(1);
        end
        else if (cap_ext > CW'(DEPTH))
        begin
            cap_eff = CW'(DEPTH);
        end
        else
        begin
            cap_eff = cap_ext;
        end
        keep     = (fill_reg >= cap_eff) ? cap_eff - CW'(1) : fill_reg;
        new_fill = hit ? fill_reg : keep + CW'(1);
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        remain_next    = remain_reg;
        count_next     = count_reg;
        cap_next       = cfg_we ? cfg_wdata : cap_reg;
        out_valid_next = out_valid_reg && !out_take;
        out_ident_next = out_ident_reg;
        out_count_next = out_count_reg;
        out_final_next = out_final_reg;
        for (int i = 0; i < DEPTH; i++)
        begin
            slots_next[i] = slots_reg[i];
        end

        if (q_pop)
        begin
            fill_next = new_fill;
            if (!hit)
            begin
                slots_next[0] = id_cur;
                for (int i = 1; i < DEPTH; i++)
                begin
                    slots_next[i] = slots_reg[i-1];
                end
            end
            if (q_head.kind == KIND_END)
            begin
                state_next  = ST_DUMP;
                remain_next = new_fill;
                count_next  = new_fill;
            end
        end

        // dump newest first by shifting toward the head
        if (do_load)
        begin
            out_valid_next = 1'b1;
            out_ident_next = head_wide[IDENT_W-1:0];
            out_count_next = count_reg[COUNT_W-1:0];
            out_final_next = (remain_reg == CW'(1));
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                slots_next[i] = slots_reg[i+1];
            end
            remain_next = remain_reg - CW'(1);
            if (remain_reg == CW'(1))
            begin
                state_next = ST_IDLE;
                fill_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            remain_reg    <= '0;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
            out_ident_reg <= '0;
            out_count_reg <= '0;
            out_final_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            remain_reg    <= remain_next;
            count_reg     <= count_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
            out_ident_reg <= out_ident_next;
            out_count_reg <= out_count_next;
            out_final_reg <= out_final_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            slots_reg[i] <= slots_next[i];
        end
    end

endmodule

// ===== hw/rtl/fifo_recent_id_list_top.sv =====
// ----------------------------------------------------------------------------
// fifo_recent_id_list_top
// path: a taken batch end passes the front queue, the dump state and the
// output register; a dump gives one entry per cycle while the sink keeps up
// throughput: one identifier per cycle while no dump runs, set by the
// combinational slot compare and shift; a dump holds the back to its end
// reset: list empty, capacity 16, both channels idle
// ----------------------------------------------------------------------------
module fifo_recent_id_list_top
#(
    parameter int DEPTH   = frl_pkg::DEPTH_DEFAULT,
    parameter int ID_BITS = frl_pkg::ID_BITS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    frl_in_if.sink                    ident_ch,
    frl_out_if.source                 result_ch,
    input  logic                      cfg_we,
    input  logic [frl_pkg::CFG_W-1:0] cfg_wdata
);
    import frl_pkg::*;

    frl_item_t q_head;
    logic      q_valid;
    logic      q_pop;

    frl_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ident_ch (ident_ch),
        .q_head   (q_head),
        .q_valid  (q_valid),
        .q_pop    (q_pop)
    );

    frl_back
    #(
        .DEPTH   (DEPTH),
        .ID_BITS (ID_BITS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_head    (q_head),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .result_ch (result_ch)
    );

endmodule

// ===== hw/rtl/frl_checker.sv =====
// ----------------------------------------------------------------------------
// frl_checker
// port checks on the dump stream of the recent id list
// ----------------------------------------------------------------------------
`include "fifo_recent_id_list_top_macros.svh"

module frl_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [frl_pkg::IDENT_W-1:0] entry_ident,
    input logic [frl_pkg::COUNT_W-1:0] stored_count,
    input logic                        final_entry
);
    import frl_pkg::*;

    // nothing offered while in reset
    `FRL_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !out_valid, "result during reset")

    // a dump always holds at least one entry
    `FRL_ASSERT_RUN(a_count_nonzero, clk, rst_n, out_valid |-> (stored_count != '0),
        "zero stored count")

    // dump runs back to back until its final entry
    `FRL_ASSERT_RUN(a_run_continues, clk, rst_n,
        (out_valid && out_ready && !final_entry) |=> out_valid, "gap inside dump run")

    // stalled transaction holds
    `FRL_ASSERT_RUN(a_stall_hold, clk, rst_n,
        (out_valid && !out_ready) |=> (out_valid && $stable(entry_ident)),
        "stalled result changed")

endmodule

bind fifo_recent_id_list_top frl_checker u_frl_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (result_ch.valid),
    .out_ready    (result_ch.ready),
    .entry_ident  (result_ch.entry_ident),
    .stored_count (result_ch.stored_count),
    .final_entry  (result_ch.final_entry)
);

// ===== bench/tb_fifo_recent_id_list_top.sv =====
// ----------------------------------------------------------------------------
// tb_fifo_recent_id_list_top
// Self-checking bench for the recent identifier list with FIFO replacement.
// A tracker class mirrors the list, the fill level and the capacity register.
// On every accepted batch end it queues the dump entries that the block
// should emit. Each entry returned on the result channel is compared with the
// oldest queued one. Directed cases come first, then four random phases with
// differing capacities and mixes of sender gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_fifo_recent_id_list_top;
    import frl_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEFAULT;

    typedef struct packed
    {
        logic [IDENT_W-1:0] ident;
        logic [COUNT_W-1:0] count;
        logic               last;
    } dump_entry_t;

    class id_list_tracker;
        logic [IDENT_W-1:0] slots [LIST_DEPTH];
        int                 fill_level;
        int                 capacity;
        dump_entry_t        due_entries [$];
        int                 errors;
        int                 entries_checked;
        int                 batches;

        function new();
            fill_level      = 0;
            capacity        = int'(CAP_RESET);
            errors          = 0;
            entries_checked = 0;
            batches         = 0;
        endfunction

        function void set_capacity(logic [CFG_W-1:0] value);
            capacity = int'(value);
        endfunction

        function int pending();
            return due_entries.size();
        endfunction

        // apply one accepted identifier, queue the dump on a batch end
        function void take_ident(logic [IDENT_W-1:0] id, logic batch_last);
            int          cap;
            int          keep;
            int          i;
            bit          hit;
            dump_entry_t e;
            cap = capacity;
            if (cap < 1)
                cap = 1;
            if (cap > LIST_DEPTH)
                cap = LIST_DEPTH;
            hit = 0;
            for (i = 0; i < fill_level; i++)
            begin
                if (slots[i] == id)
                    hit = 1;
            end
            if (!hit)
            begin
                keep = fill_level;
                if (keep >= cap)
                    keep = cap - 1;
                for (i = keep; i > 0; i--)
                    slots[i] = slots[i-1];
                slots[0]   = id;
                fill_level = keep + 1;
            end
            if (batch_last)
            begin
                for (i = 0; i < fill_level; i++)
                begin
                    e.ident = slots[i];
                    e.count = COUNT_W'(fill_level);
                    e.last  = (i == fill_level - 1);
                    due_entries = {due_entries, e};
                end
                fill_level = 0;
                batches++;
            end
        endfunction

        function void match_entry(logic [IDENT_W-1:0] id, logic [COUNT_W-1:0] count,
                                  logic last);
            dump_entry_t e;
            if (due_entries.size() == 0)
            begin
                $display("%0t: unexpected entry ident %h count %0d final %b",
                         $time, id, count, last);
                errors++;
                return;
            end
            e = due_entries.pop_front();
            entries_checked++;
            if (id !== e.ident)
            begin
                $display("%0t: entry_ident expected %h actual %h", $time, e.ident, id);
                errors++;
            end
            if (count !== e.count)
            begin
                $display("%0t: stored_count expected %0d actual %0d", $time, e.count, count);
                errors++;
            end
            if (last !== e.last)
            begin
                $display("%0t: final_entry expected %b actual %b", $time, e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    int               send_idle_pct;
    int               sink_stall_pct;
    int               idents_sent;
    id_list_tracker   book;

    frl_in_if  ident_ch();
    frl_out_if result_ch();

    fifo_recent_id_list_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ident_ch  (ident_ch),
        .result_ch (result_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // sink back-pressure
    always @(negedge clk)
        result_ch.ready = ($urandom_range(99) >= sink_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            book.match_entry(result_ch.entry_ident, result_ch.stored_count,
                             result_ch.final_entry);
    end

    task automatic send_ident(input logic [IDENT_W-1:0] id, input logic batch_last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            ident_ch.valid = 1'b0;
            @(negedge clk);
        end
        ident_ch.valid     = 1'b1;
        ident_ch.ident     = id;
        ident_ch.batch_end = batch_last;
        @(posedge clk);
        while (!ident_ch.ready)
            @(posedge clk);
        book.take_ident(id, batch_last);
        idents_sent++;
        @(negedge clk);
    endtask

    // hold the sender until every due entry is back and the block is quiet
    task automatic settle();
        ident_ch.valid = 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(posedge clk);
        book.set_capacity(value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    initial
    begin
        #1000000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        logic [IDENT_W-1:0] base;
        logic [IDENT_W-1:0] id;
        logic [CFG_W-1:0]   phase_cap;
        int                 phase;
        int                 done;
        int                 len;
        int                 j;

        book               = new();
        clk                = 1'b0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        ident_ch.valid     = 1'b0;
        ident_ch.ident     = '0;
        ident_ch.batch_end = 1'b0;
        result_ch.ready    = 1'b0;
        send_idle_pct      = 0;
        sink_stall_pct     = 0;
        idents_sent        = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // extreme identifiers, a hit, dump at reset capacity
        send_ident(32'h0000_0000, 1'b0);
        send_ident(32'hFFFF_FFFF, 1'b0);
        send_ident(32'h0000_0000, 1'b0);
        send_ident(32'hFFFF_FFFF, 1'b1);
        // batch end on an empty list
        send_ident(32'h5A5A_A5A5, 1'b1);
        settle();

        // eviction of the oldest at a full list
        write_capacity(5'd3);
        for (j = 0; j < 5; j++)
            send_ident(32'h1000_0000 + j, j == 4);
        settle();

        // zero capacity acts as one
        write_capacity(5'd0);
        send_ident(32'h2222_2222, 1'b0);
        send_ident(32'h3333_3333, 1'b1);
        settle();

        // capacity lowered below the fill level
        write_capacity(5'd16);
        for (j = 0; j < 6; j++)
            send_ident(32'h4000_0000 + j, 1'b0);
        settle();
        write_capacity(5'd2);
        send_ident(32'h4000_0000, 1'b0);
        send_ident(32'h4000_00FF, 1'b1);
        settle();

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin phase_cap = 5'd31; send_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin phase_cap = CFG_W'($urandom_range(2, 15));
                         send_idle_pct = 48; sink_stall_pct = 0;  end
                2: begin phase_cap = 5'd16; send_idle_pct = 0;  sink_stall_pct = 48; end
                default: begin phase_cap = CFG_W'($urandom_range(0, 31));
                         send_idle_pct = 31; sink_stall_pct = 31; end
            endcase
            write_capacity(phase_cap);
            done = 0;
            while (done < 20)
            begin
                len  = $urandom_range(1, 20);
                base = $urandom;
                for (j = 0; j < len; j++)
                begin
                    // mostly a small pool so that hits are common
                    if ($urandom_range(9) == 0)
                        id = $urandom;
                    else
                        id = base + $urandom_range(0, 23);
                    send_ident(id, j == len - 1);
                    done++;
                end
            end
            settle();
        end

        send_idle_pct  = 0;
        sink_stall_pct = 0;
        settle();
        $display("covered %0d identifiers in %0d batches, %0d dumped entries checked",
                 idents_sent, book.batches, book.entries_checked);
        $display("capacities zero, small, full and saturating; gaps and stalls mixed");
        if (book.errors == 0 && book.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/frl_pkg.sv
hw/rtl/frl_channels.sv
hw/rtl/frl_front.sv
hw/rtl/frl_back.sv
hw/rtl/fifo_recent_id_list_top.sv
hw/rtl/frl_checker.sv
bench/tb_fifo_recent_id_list_top.sv
